/* design/pcwc_pkg.sv */
// ----------------------------------------------------------------------------
// pcwc_pkg
// Shared types, constants and helpers for the plane coincidence window counter.
// ----------------------------------------------------------------------------
package pcwc_pkg;

    localparam int NUM_CHANNELS_DEF = 36;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_EVENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIPPED_CHAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_START     = 2'd2;

    localparam logic [19:0] WINDOW_EVENTS_RST = 20'd100000;
    localparam logic [5:0]  SKIPPED_CHAN_RST  = 6'd11;
    localparam logic [1:0]  CHIP_INVALID      = 2'd3;
    localparam logic [1:0]  TALLY_MAX         = 2'd3;

    // divide by 1000 as multiply by floor(2^37 / 1000), then one correction
    localparam int          MS_W         = 27;
    localparam int          DIV_MULT_W   = 28;
    localparam int          DIV_SHIFT    = 37;
    localparam int          PROD_W       = MS_W + DIV_MULT_W;
    localparam int          QUOT_W       = PROD_W - DIV_SHIFT;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 28'd137438953;
    localparam logic [9:0]  MS_PER_S     = 10'd1000;

    typedef logic [2:0][1:0] t_tally;

    typedef struct packed {
        logic        action;
        logic [5:0]  channel;
        logic [1:0]  chip;
        logic [7:0]  clusters;
        logic [26:0] event_time_ms;
    } t_in_word;

    typedef struct packed {
        logic [31:0] event_number;
        logic [31:0] timestamp;
        logic [31:0] single_hit_planes;
        logic [31:0] double_hit_planes;
        logic [31:0] triple_hit_planes;
        logic [31:0] single_coincidences;
        logic [31:0] double_coincidences;
        logic [31:0] triple_coincidences;
    } t_out_word;

    typedef struct packed {
        logic       shift;
        logic       upd;
        logic [1:0] chip;
        logic [7:0] clusters;
    } t_cell_ctl;

    typedef struct packed {
        logic scan;
        logic clear;
    } t_coll_ctl;

    typedef struct packed {
        logic [31:0] cnt1;
        logic [31:0] cnt2;
        logic [31:0] cnt3;
    } t_coin_counts;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

/* design/pcwc_cell.sv */
// ----------------------------------------------------------------------------
// pcwc_cell
// One channel: three saturating 2-bit cluster tallies, shifted down the chain
// during the end-of-event scan.
// ----------------------------------------------------------------------------
module pcwc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcwc_pkg::t_cell_ctl i_ctl,
    input  logic                i_sel,
    input  pcwc_pkg::t_tally    i_next,
    output pcwc_pkg::t_tally    o_tally
);

    pcwc_pkg::t_tally r_tally;
    pcwc_pkg::t_tally n_tally;
    logic [2:0]       w_sum;

    always_comb begin
        n_tally = r_tally;
        w_sum   = {1'b0, r_tally[i_ctl.chip]} + {1'b0, i_ctl.clusters[1:0]};
        if (i_ctl.shift) begin
            n_tally = i_next;
        end else if (i_ctl.upd && i_sel && i_ctl.chip != pcwc_pkg::CHIP_INVALID) begin
            if (|i_ctl.clusters[7:2] || w_sum[2] || w_sum[1:0] == pcwc_pkg::TALLY_MAX) begin
                n_tally[i_ctl.chip] = pcwc_pkg::TALLY_MAX;
            end else begin
                n_tally[i_ctl.chip] = w_sum[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else begin
            r_tally <= n_tally;
        end
    end

    assign o_tally = r_tally;

endmodule

/* design/pcwc_collector.sv */
// ----------------------------------------------------------------------------
// pcwc_collector
// Classifies the tally at the head of the chain, one channel per cycle, and
// keeps the saturating window coincidence counts.
// ----------------------------------------------------------------------------
module pcwc_collector (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pcwc_pkg::t_coll_ctl    i_ctl,
    input  pcwc_pkg::t_tally       i_tally,
    output pcwc_pkg::t_coin_counts o_counts
);

    pcwc_pkg::t_coin_counts r_counts;
    pcwc_pkg::t_coin_counts n_counts;
    logic [1:0]             w_min01;
    logic [1:0]             w_min;

    always_comb begin
        w_min01  = (i_tally[0] < i_tally[1]) ? i_tally[0] : i_tally[1];
        w_min    = (i_tally[2] < w_min01) ? i_tally[2] : w_min01;
        n_counts = r_counts;
        if (i_ctl.clear) begin
            n_counts = '0;
        end else if (i_ctl.scan) begin
            case (w_min)
                2'd3:    n_counts.cnt3 = pcwc_pkg::sat_inc(r_counts.cnt3);
                2'd2:    n_counts.cnt2 = pcwc_pkg::sat_inc(r_counts.cnt2);
                2'd1:    n_counts.cnt1 = pcwc_pkg::sat_inc(r_counts.cnt1);
                default: n_counts = r_counts;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else begin
            r_counts <= n_counts;
        end
    end

    assign o_counts = r_counts;

endmodule

/* design/plane_coincidence_window_counter_core.sv */
// ----------------------------------------------------------------------------
// plane_coincidence_window_counter_core
// Counts plane hits and per-channel chip coincidences over windows of events
// and emits one summary word per window.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+---------------------------
//   in      | into core | i_in_valid / o_in_stall | pcwc_pkg::t_in_word
//   out     | from core | o_out_valid/ i_out_stall| pcwc_pkg::t_out_word
//   cfg     | into core | i_cfg_valid/ o_cfg_ready| index 2 bit, data 32 bit
//
// A plane record does not stall the input. An end-of-event word stalls it
// after it is taken: the tallies shift one channel a cycle through the cell
// chain into the collector, then states S_QEST and S_QUOT do the divide by
// 1000, then S_DONE closes the event; if the event ends a window, S_DONE
// waits while an earlier summary word is still stalled.
// Reset is synchronous; all tallies and counters clear at once.
// ----------------------------------------------------------------------------
module plane_coincidence_window_counter_core #(
    parameter int NUM_CHANNELS = pcwc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  pcwc_pkg::t_in_word                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output pcwc_pkg::t_out_word                   o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pcwc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pcwc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CNT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CHANNELS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_QEST = 3'd2;
    localparam logic [2:0] S_QUOT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // configuration
    logic [19:0] r_win_events;
    logic [5:0]  r_skip;
    logic [31:0] r_day_start;

    // control
    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_evt;
    logic [19:0]      r_pos;
    logic             r_out_valid;
    logic [31:0]      r_hit1;
    logic [31:0]      r_hit2;
    logic [31:0]      r_hit3;

    // payload
    logic [pcwc_pkg::MS_W-1:0]   r_time;
    logic [pcwc_pkg::PROD_W-1:0] r_prod;
    logic [pcwc_pkg::QUOT_W-1:0] r_qest;
    logic [pcwc_pkg::QUOT_W-1:0] r_quot;
    pcwc_pkg::t_out_word         r_out;

    logic                   w_in_acc;
    logic                   w_plane_ok;
    logic [5:0]             w_chan_m1;
    logic [27:0]            w_qmul;
    logic [27:0]            w_rem;
    logic [19:0]            w_pos_next;
    logic [19:0]            w_limit;
    logic                   w_win_end;
    logic                   w_can_close;
    pcwc_pkg::t_cell_ctl    w_cell_ctl;
    pcwc_pkg::t_coll_ctl    w_coll_ctl;
    pcwc_pkg::t_coin_counts w_coin;
    pcwc_pkg::t_tally       w_tally [NUM_CHANNELS+1];
    logic [NUM_CHANNELS-1:0] w_sel;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_chan_m1  = i_in_data.channel - 6'd1;
    assign w_plane_ok = (i_in_data.chip != pcwc_pkg::CHIP_INVALID)
                     && !(r_skip != 6'd0 && i_in_data.channel == r_skip)
                     && (i_in_data.channel != 6'd0)
                     && (i_in_data.channel <= 6'(NUM_CHANNELS));

    assign w_cell_ctl.shift    = (r_state == S_SCAN);
    assign w_cell_ctl.upd      = w_in_acc && !i_in_data.action && w_plane_ok;
    assign w_cell_ctl.chip     = i_in_data.chip;
    assign w_cell_ctl.clusters = i_in_data.clusters;

    // the far end of the chain feeds zeros, which clears the tallies
    assign w_tally[NUM_CHANNELS] = '0;

    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_cell
        assign w_sel[k] = (w_chan_m1 == 6'(k));
        pcwc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_cell_ctl),
            .i_sel   (w_sel[k]),
            .i_next  (w_tally[k+1]),
            .o_tally (w_tally[k])
        );
    end

    assign w_limit     = (r_win_events == 20'd0) ? 20'd1 : r_win_events;
    assign w_pos_next  = r_pos + 20'd1;
    assign w_win_end   = (w_pos_next >= w_limit);
    assign w_can_close = !(w_win_end && r_out_valid && i_out_stall);

    assign w_coll_ctl.scan  = (r_state == S_SCAN);
    assign w_coll_ctl.clear = (r_state == S_DONE) && w_can_close && w_win_end;

    pcwc_collector u_collector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_coll_ctl),
        .i_tally  (w_tally[0]),
        .o_counts (w_coin)
    );

    // remainder check: the estimate is the quotient or one below it
    assign w_qmul = 28'(r_qest) * 28'(pcwc_pkg::MS_PER_S);
    assign w_rem  = 28'(r_time) - w_qmul;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_data.action) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_QEST;
                end
            end
            S_QEST:  n_state = S_QUOT;
            S_QUOT:  n_state = S_DONE;
            S_DONE: begin
                if (w_can_close) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_events <= pcwc_pkg::WINDOW_EVENTS_RST;
            r_skip       <= pcwc_pkg::SKIPPED_CHAN_RST;
            r_day_start  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pcwc_pkg::REG_WINDOW_EVENTS: r_win_events <= i_cfg_data[19:0];
                pcwc_pkg::REG_SKIPPED_CHAN:  r_skip       <= i_cfg_data[5:0];
                pcwc_pkg::REG_DAY_START:     r_day_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_evt       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_hit1      <= '0;
            r_hit2      <= '0;
            r_hit3      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN) begin
                r_cnt <= (r_cnt == CNT_LAST) ? '0 : r_cnt + CNT_W'(1);
            end
            if (w_cell_ctl.upd) begin
                if (i_in_data.clusters == 8'd1) begin
                    r_hit1 <= pcwc_pkg::sat_inc(r_hit1);
                end else if (i_in_data.clusters == 8'd2) begin
                    r_hit2 <= pcwc_pkg::sat_inc(r_hit2);
                end else if (i_in_data.clusters >= 8'd3) begin
                    r_hit3 <= pcwc_pkg::sat_inc(r_hit3);
                end
            end
            // a new summary may be loaded in the cycle the old one is taken
            if (r_state == S_DONE && w_can_close && w_win_end) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && w_can_close) begin
                r_evt <= r_evt + 32'd1;
                if (w_win_end) begin
                    r_pos  <= '0;
                    r_hit1 <= '0;
                    r_hit2 <= '0;
                    r_hit3 <= '0;
                end else begin
                    r_pos <= w_pos_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.action) begin
            r_time <= i_in_data.event_time_ms;
        end
        r_prod <= pcwc_pkg::PROD_W'(r_time) * pcwc_pkg::PROD_W'(pcwc_pkg::DIV_MULT);
        r_qest <= r_prod[pcwc_pkg::PROD_W-1:pcwc_pkg::DIV_SHIFT];
        r_quot <= (w_rem >= 28'(pcwc_pkg::MS_PER_S)) ? r_qest + pcwc_pkg::QUOT_W'(1) : r_qest;
        if (r_state == S_DONE && w_can_close && w_win_end) begin
            r_out.event_number        <= r_evt + 32'd1;
            r_out.timestamp           <= r_day_start + 32'(r_quot);
            r_out.single_hit_planes   <= r_hit1;
            r_out.double_hit_planes   <= r_hit2;
            r_out.triple_hit_planes   <= r_hit3;
            r_out.single_coincidences <= w_coin.cnt1;
            r_out.double_coincidences <= w_coin.cnt2;
            r_out.triple_coincidences <= w_coin.cnt3;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // chain is empty once the scan is over
    a_chain_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QEST) |-> (w_tally[0] == '0))
        else $error("cell chain not cleared after scan");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |-> (r_cnt == '0))
        else $error("scan counter left nonzero");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("summary word raised outside event close");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUOT) |-> (w_rem < 28'd2000))
        else $error("divide estimate off by more than one");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the plane coincidence window counter core. A short
// table of hand-built events, some with their summary typed in, is followed by
// random events over several register settings. An in-bench model of the hit
// counters, the channel tallies and the event window predicts each summary
// word not typed in; a monitor compares them field by field as they are taken.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_CH     = pcwc_pkg::NUM_CHANNELS_DEF;
    localparam int SETTLE_CYC = pcwc_pkg::NUM_CHANNELS_DEF + 20;
    localparam int CYC_LIMIT  = 600000;
    localparam int PHASE_WORDS = 150;
    localparam int N_PHASES   = 6;
    localparam int LONG_HOLD  = 400;

    localparam logic ACT_PLANE = 1'b0;
    localparam logic ACT_EOE   = 1'b1;

    typedef struct {
        pcwc_pkg::t_in_word  w;
        bit                  typed;
        pcwc_pkg::t_out_word sum;
    } t_stim_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    pcwc_pkg::t_in_word in_data = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [pcwc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pcwc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    pcwc_pkg::t_out_word o_out_data;
    logic        o_cfg_ready;

    // window model
    logic [19:0] win_len   = pcwc_pkg::WINDOW_EVENTS_RST;
    logic [5:0]  skip_ch   = pcwc_pkg::SKIPPED_CHAN_RST;
    logic [31:0] day_start = '0;
    logic [1:0]  tally [NUM_CH][3];
    logic [31:0] hit_cnt [3];
    logic [31:0] coin_cnt [3];
    logic [31:0] ev_count = '0;
    int unsigned win_pos  = 0;

    pcwc_pkg::t_out_word summary_q [$];
    t_stim_row   dir_tab [$];
    int          fail_cnt  = 0;
    int          seen_cnt  = 0;
    int          words_sent = 0;
    int          events_sent = 0;
    int          cycles    = 0;
    bit          in_burst  = 1'b0;
    bit          out_burst = 1'b0;
    bit          long_hold_done = 1'b0;

    plane_coincidence_window_counter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d summaries pending", cycles,
                     summary_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < NUM_CH; c++) begin
            for (int k = 0; k < 3; k++) begin
                tally[c][k] = '0;
            end
        end
        for (int k = 0; k < 3; k++) begin
            hit_cnt[k]  = '0;
            coin_cnt[k] = '0;
        end
    end

    // updates the window model with one accepted word
    task automatic count_word(input pcwc_pkg::t_in_word w, output bit closes,
                              output pcwc_pkg::t_out_word s);
        int unsigned lim;
        int unsigned sum;
        int          k;
        logic [1:0]  m;
        closes = 1'b0;
        s = '0;
        if (w.action == ACT_PLANE) begin
            if (w.chip == pcwc_pkg::CHIP_INVALID) return;
            if (skip_ch != 0 && w.channel == skip_ch) return;
            if (w.channel < 1 || w.channel > NUM_CH) return;
            k = (w.clusters == 1) ? 0 : (w.clusters == 2) ? 1 : (w.clusters >= 3) ? 2 : -1;
            if (k >= 0 && hit_cnt[k] != '1) hit_cnt[k]++;
            sum = 32'(tally[w.channel-1][w.chip]) + 32'(w.clusters);
            tally[w.channel-1][w.chip] = (sum > 3) ? 2'd3 : sum[1:0];
            return;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            m = tally[c][0];
            if (tally[c][1] < m) m = tally[c][1];
            if (tally[c][2] < m) m = tally[c][2];
            k = (m == 3) ? 2 : (m == 2) ? 1 : (m == 1) ? 0 : -1;
            if (k >= 0 && coin_cnt[k] != '1) coin_cnt[k]++;
            for (int j = 0; j < 3; j++) tally[c][j] = '0;
        end
        ev_count++;
        win_pos++;
        lim = (win_len == 0) ? 1 : 32'(win_len);
        if (win_pos < lim) return;
        s.event_number        = ev_count;
        s.timestamp           = day_start + 32'(w.event_time_ms / 1000);
        s.single_hit_planes   = hit_cnt[0];
        s.double_hit_planes   = hit_cnt[1];
        s.triple_hit_planes   = hit_cnt[2];
        s.single_coincidences = coin_cnt[0];
        s.double_coincidences = coin_cnt[1];
        s.triple_coincidences = coin_cnt[2];
        for (int j = 0; j < 3; j++) begin
            hit_cnt[j]  = '0;
            coin_cnt[j] = '0;
        end
        win_pos = 0;
        closes = 1'b1;
    endtask

    task automatic push_word(input pcwc_pkg::t_in_word w, input bit typed,
                             input pcwc_pkg::t_out_word given);
        int                  gap;
        bit                  closes;
        pcwc_pkg::t_out_word s;
        pcwc_pkg::t_out_word want;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        if (w.action == ACT_EOE) events_sent++;
        count_word(w, closes, s);
        if (closes) begin
            want = typed ? given : s;
            summary_q.insert(summary_q.size(), want);
        end
    endtask

    task automatic add_row(input t_stim_row r);
        dir_tab.insert(dir_tab.size(), r);
    endtask

    task automatic write_reg(input logic [pcwc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pcwc_pkg::REG_WINDOW_EVENTS: win_len   = val[19:0];
            pcwc_pkg::REG_SKIPPED_CHAN:  skip_ch   = val[5:0];
            pcwc_pkg::REG_DAY_START:     day_start = val;
            default: ;
        endcase
    endtask

    // sender stops and waits for every summary, then for the core to go quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic pcwc_pkg::t_in_word plane(input int ch, input int chip, input int cl);
        pcwc_pkg::t_in_word w;
        w = '0;
        w.action   = ACT_PLANE;
        w.channel  = ch[5:0];
        w.chip     = chip[1:0];
        w.clusters = cl[7:0];
        return w;
    endfunction

    function automatic pcwc_pkg::t_in_word eoe(input int ms);
        pcwc_pkg::t_in_word w;
        w = '0;
        w.action        = ACT_EOE;
        w.event_time_ms = ms[26:0];
        return w;
    endfunction

    function automatic pcwc_pkg::t_out_word summ(input int ev, input int ts, input int h1,
                                                 input int h2, input int h3, input int c1,
                                                 input int c2, input int c3);
        pcwc_pkg::t_out_word s;
        s = '{ev, ts, h1, h2, h3, c1, c2, c3};
        return s;
    endfunction

    function automatic t_stim_row row(input pcwc_pkg::t_in_word w, input bit typed = 1'b0,
                                      input pcwc_pkg::t_out_word s = '0);
        t_stim_row r;
        r.w = w;
        r.typed = typed;
        r.sum = s;
        return r;
    endfunction

    function automatic pcwc_pkg::t_in_word rand_plane(input int ch, input int chip);
        pcwc_pkg::t_in_word w;
        w = plane(ch, chip, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 3));
        w.event_time_ms = 27'($urandom);
        return w;
    endfunction

    // planes the core must drop
    function automatic pcwc_pkg::t_in_word noise_word();
        pcwc_pkg::t_in_word w;
        w = rand_plane($urandom_range(1, NUM_CH), $urandom_range(0, 2));
        w.clusters = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: begin
                w.chip    = pcwc_pkg::CHIP_INVALID;
                w.channel = 6'($urandom_range(0, 63));
            end
            1: w.channel = skip_ch;
            2: w.channel = '0;
            default: begin
                w.channel = 6'($urandom_range(NUM_CH + 1, 63));
                w.chip    = 2'($urandom_range(0, 3));
            end
        endcase
        return w;
    endfunction

    task automatic send_event(output int useful);
        int                 n_tgt;
        int                 n_extra;
        int                 ch;
        logic [63:0]        junk;
        pcwc_pkg::t_in_word w;
        useful  = 0;
        n_tgt   = $urandom_range(0, 3);
        n_extra = $urandom_range(0, 3);
        for (int t = 0; t < n_tgt; t++) begin
            ch = $urandom_range(1, NUM_CH);
            for (int c = 0; c < 3; c++) begin
                if ($urandom_range(0, 7) != 0) begin
                    push_word(rand_plane(ch, c), 1'b0, '0);
                    useful++;
                end
            end
            if ($urandom_range(0, 4) == 0) push_word(noise_word(), 1'b0, '0);
        end
        for (int e = 0; e < n_extra; e++) begin
            push_word(rand_plane($urandom_range(1, NUM_CH), $urandom_range(0, 2)), 1'b0, '0);
            useful++;
        end
        // end-of-event words carry junk in the plane fields
        junk = {$urandom, $urandom};
        w = junk[$bits(pcwc_pkg::t_in_word)-1:0];
        w.action = ACT_EOE;
        push_word(w, 1'b0, '0);
        useful++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        pcwc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (summary_q.size() == 0) begin
                $error("summary word with none expected: event_number %0d",
                       o_out_data.event_number);
                fail_cnt++;
            end else begin
                want = summary_q.pop_front();
                check_field("event_number", want.event_number, o_out_data.event_number);
                check_field("timestamp", want.timestamp, o_out_data.timestamp);
                check_field("single_hit_planes", want.single_hit_planes,
                            o_out_data.single_hit_planes);
                check_field("double_hit_planes", want.double_hit_planes,
                            o_out_data.double_hit_planes);
                check_field("triple_hit_planes", want.triple_hit_planes,
                            o_out_data.triple_hit_planes);
                check_field("single_coincidences", want.single_coincidences,
                            o_out_data.single_coincidences);
                check_field("double_coincidences", want.double_coincidences,
                            o_out_data.double_coincidences);
                check_field("triple_coincidences", want.triple_coincidences,
                            o_out_data.triple_coincidences);
            end
            seen_cnt++;
        end
    end

    // receiver: random stall before each word, one long hold-off to back up the core
    initial begin
        int gap;
        forever begin
            if (!long_hold_done && seen_cnt >= 12) begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = out_burst ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    initial begin
        int useful;
        int sent;
        logic [19:0] w_len;
        logic [5:0]  w_skip;
        logic [31:0] w_day;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty event, single/double/triple coincidences, time rounding,
        // tally saturation, dropped planes and a junk end-of-event word
        add_row(row(eoe(0), 1'b1, summ(1, 0, 0, 0, 0, 0, 0, 0)));
        add_row(row(plane(1, 0, 1)));
        add_row(row(plane(1, 1, 1)));
        add_row(row(plane(1, 2, 1)));
        add_row(row(eoe(999), 1'b1, summ(2, 0, 3, 0, 0, 1, 0, 0)));
        add_row(row(plane(NUM_CH, 0, 2)));
        add_row(row(plane(NUM_CH, 1, 2)));
        add_row(row(plane(NUM_CH, 2, 2)));
        add_row(row(eoe(1000), 1'b1, summ(3, 1, 0, 3, 0, 0, 1, 0)));
        add_row(row(plane(5, 0, 255)));
        add_row(row(plane(5, 1, 255)));
        add_row(row(plane(5, 2, 255)));
        add_row(row(plane(5, 0, 0)));
        add_row(row(eoe(134217727), 1'b1, summ(4, 134217, 0, 0, 3, 0, 0, 1)));
        add_row(row(plane(2, 0, 2)));
        add_row(row(plane(2, 0, 2)));
        add_row(row(plane(2, 1, 3)));
        add_row(row(plane(2, 2, 1)));
        add_row(row(eoe(5000)));
        add_row(row(plane(2, pcwc_pkg::CHIP_INVALID, 1)));
        add_row(row(plane(pcwc_pkg::SKIPPED_CHAN_RST, 0, 1)));
        add_row(row(plane(0, 1, 1)));
        add_row(row(plane(NUM_CH + 1, 2, 1)));
        add_row(row(plane(63, 0, 255)));
        add_row(row('{ACT_EOE, 6'd63, pcwc_pkg::CHIP_INVALID, 8'd255, 27'd0}, 1'b1,
                    summ(6, 0, 0, 0, 0, 0, 0, 0)));

        write_reg(pcwc_pkg::REG_WINDOW_EVENTS, 32'd1);
        cfg_valid <= 1'b0;
        foreach (dir_tab[i]) push_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].sum);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin w_len = 20'd3;     w_skip = 6'd0;  w_day = 32'd0;          end
                1: begin w_len = 20'd0;     w_skip = 6'd63; w_day = 32'hFFFF_FFFF; end
                2: begin
                    w_len  = 20'hFFFFF;
                    w_skip = pcwc_pkg::SKIPPED_CHAN_RST;
                    w_day  = $urandom;
                end
                3: begin
                    // window shrinks below the position left by the long window
                    w_len  = 20'd2;
                    w_skip = 6'($urandom_range(1, NUM_CH));
                    w_day  = $urandom;
                end
                4: begin w_len = 20'd1; w_skip = 6'(NUM_CH); w_day = 32'h8000_0000; end
                default: begin
                    w_len  = 20'($urandom_range(1, 6));
                    w_skip = 6'd1;
                    w_day  = $urandom;
                end
            endcase
            write_reg(pcwc_pkg::REG_WINDOW_EVENTS, {12'd0, w_len});
            write_reg(pcwc_pkg::REG_SKIPPED_CHAN, {26'd0, w_skip});
            write_reg(pcwc_pkg::REG_DAY_START, w_day);
            cfg_valid <= 1'b0;
            in_burst  = (p == 4);
            out_burst = (p == 1);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                send_event(useful);
                sent += useful;
            end
            drain();
        end

        $display("sent %0d words in %0d events over %0d register settings",
                 words_sent, events_sent, N_PHASES + 1);
        $display("checked %0d summary words, %0d mismatches", seen_cnt, fail_cnt);
        if (fail_cnt == 0 && summary_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
